// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the shape pair collision test.
// Needs nothing else; files that assert take it in by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define SPCT_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: condition does not hold");

// When the trigger holds, the result holds at the next clock edge.
`define SPCT_ASSERT_NEXT(label, clk, rst, trig, res) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (res)) \
      else $error("assertion failed: next-cycle result does not hold");

`endif

// File: hw/rtl/spct_pkg.sv
// Package for the shape pair collision test: opcodes, register indexes,
// field sizes and the pipeline control word. Depends on nothing.
`default_nettype none

package spct_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int OPCODE_BITS        = 4;
   localparam int FIELD_BITS         = 15;
   localparam int CSR_INDEX_BITS     = 2;

   localparam logic [FIELD_BITS-1:0] FIELD_WIDTH_RESET  = FIELD_BITS'(640);
   localparam logic [FIELD_BITS-1:0] FIELD_HEIGHT_RESET = FIELD_BITS'(320);

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIELD_WIDTH  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIELD_HEIGHT = CSR_INDEX_BITS'(1);

   // Test opcodes.
   localparam logic [OPCODE_BITS-1:0] OP_RR_OVERLAP   = 4'd0;
   localparam logic [OPCODE_BITS-1:0] OP_RC_OVERLAP   = 4'd1;
   localparam logic [OPCODE_BITS-1:0] OP_CC_OVERLAP   = 4'd2;
   localparam logic [OPCODE_BITS-1:0] OP_RR_INSIDE    = 4'd3;
   localparam logic [OPCODE_BITS-1:0] OP_RC_INSIDE    = 4'd4;
   localparam logic [OPCODE_BITS-1:0] OP_CR_INSIDE    = 4'd5;
   localparam logic [OPCODE_BITS-1:0] OP_CC_INSIDE    = 4'd6;
   localparam logic [OPCODE_BITS-1:0] OP_RECT_OUT_ANY = 4'd7;
   localparam logic [OPCODE_BITS-1:0] OP_RECT_OUT_ALL = 4'd8;
   localparam logic [OPCODE_BITS-1:0] OP_CIRC_OUT_ANY = 4'd9;
   localparam logic [OPCODE_BITS-1:0] OP_CIRC_OUT_ALL = 4'd10;

   // Control word that follows a word down the pipeline.
   typedef struct packed {
      logic [OPCODE_BITS-1:0] op;
      logic                   strict;
      logic                   lin_hit;     // result of the tests that need no squares
      logic                   use_corner;  // circle centre lies off a corner of the rect
      logic                   corner_x;    // corner on the right edge
      logic                   corner_y;    // corner on the top edge
      logic                   box_hit;     // circle bounding box meets the rect
      logic                   bw_ge_aw;    // outer radius not below inner radius
   } spct_ctl_type;

endpackage

`default_nettype wire

// File: hw/rtl/spct_dist.sv
// Squared-distance stages of the shape pair collision test: squares, then sums.
// Depends on spct_pkg for the control word.
`default_nettype none

module spct_dist import spct_pkg::*; #(
   parameter int MAG_BITS = COORD_BITS_DEFAULT + 1,
   parameter int RAD_BITS = COORD_BITS_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    en,
   input  wire logic                    in_valid,
   input  wire spct_ctl_type            in_ctl,
   input  wire logic [MAG_BITS-1:0]     dx0,
   input  wire logic [MAG_BITS-1:0]     dx1,
   input  wire logic [MAG_BITS-1:0]     dy0,
   input  wire logic [MAG_BITS-1:0]     dy1,
   input  wire logic [RAD_BITS-1:0]     rad,
   output logic                         out_valid,
   output spct_ctl_type                 out_ctl,
   output logic [2*MAG_BITS:0]          d00,
   output logic [2*MAG_BITS:0]          d01,
   output logic [2*MAG_BITS:0]          d10,
   output logic [2*MAG_BITS:0]          d11,
   output logic [2*RAD_BITS-1:0]        rr
);

   localparam int SQ_BITS   = 2 * MAG_BITS;
   localparam int DIST_BITS = SQ_BITS + 1;

   logic                  sq_valid_ff;
   spct_ctl_type          sq_ctl_ff;
   logic [SQ_BITS-1:0]    sx0_ff, sx1_ff, sy0_ff, sy1_ff;
   logic [2*RAD_BITS-1:0] srr_ff;

   logic                  sum_valid_ff;
   spct_ctl_type          sum_ctl_ff;
   logic [DIST_BITS-1:0]  d00_ff, d01_ff, d10_ff, d11_ff;
   logic [2*RAD_BITS-1:0] rr_ff;

   // Valid bits of both stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else if (en) begin
         sq_valid_ff  <= in_valid;
         sum_valid_ff <= sq_valid_ff;
      end
   end

   // First stage: one multiplier for each term.
   always_ff @(posedge clock) begin
      if (en) begin
         sq_ctl_ff <= in_ctl;
         sx0_ff    <= SQ_BITS'(dx0) * SQ_BITS'(dx0);
         sx1_ff    <= SQ_BITS'(dx1) * SQ_BITS'(dx1);
         sy0_ff    <= SQ_BITS'(dy0) * SQ_BITS'(dy0);
         sy1_ff    <= SQ_BITS'(dy1) * SQ_BITS'(dy1);
         srr_ff    <= (2*RAD_BITS)'(rad) * (2*RAD_BITS)'(rad);
      end
   end

   // Second stage: squared distances to the four corner combinations.
   always_ff @(posedge clock) begin
      if (en) begin
         sum_ctl_ff <= sq_ctl_ff;
         d00_ff     <= {1'b0, sx0_ff} + {1'b0, sy0_ff};
         d01_ff     <= {1'b0, sx0_ff} + {1'b0, sy1_ff};
         d10_ff     <= {1'b0, sx1_ff} + {1'b0, sy0_ff};
         d11_ff     <= {1'b0, sx1_ff} + {1'b0, sy1_ff};
         rr_ff      <= srr_ff;
      end
   end

   assign out_valid = sum_valid_ff;
   assign out_ctl   = sum_ctl_ff;
   assign d00       = d00_ff;
   assign d01       = d01_ff;
   assign d10       = d10_ff;
   assign d11       = d11_ff;
   assign rr        = rr_ff;

endmodule

`default_nettype wire

// File: hw/rtl/shape_pair_collision_test.sv
// Top level of the shape pair collision test: decode stage, field registers,
// final compare and output register. Depends on spct_pkg, spct_dist and
// assert_macros.svh.
//
//   channel   direction   handshake            payload
//   req       in          req_valid/req_stall  opcode, strict, a_*, b_*
//   rsp       out         rsp_valid/rsp_stall  hit
//   csr       in          csr_valid/csr_ready  csr_index, csr_wdata
//
// One word is taken every cycle while the output is not held; each word passes through
// decode and linear tests, squares, sums, and the compare into the output register.
// Reset is synchronous; it empties the pipeline and sets the field to 640 by 320.
// A stall on rsp while a result is valid holds every stage and is passed straight back as req_stall.
// csr_ready is always high; writes take effect at once.
`default_nettype none

module shape_pair_collision_test import spct_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [OPCODE_BITS-1:0]        req_opcode,
   input  wire logic                          req_strict,
   input  wire logic signed [COORD_BITS-1:0]  req_a_x,
   input  wire logic signed [COORD_BITS-1:0]  req_a_y,
   input  wire logic [COORD_BITS-2:0]         req_a_w,
   input  wire logic [COORD_BITS-2:0]         req_a_h,
   input  wire logic signed [COORD_BITS-1:0]  req_b_x,
   input  wire logic signed [COORD_BITS-1:0]  req_b_y,
   input  wire logic [COORD_BITS-2:0]         req_b_w,
   input  wire logic [COORD_BITS-2:0]         req_b_h,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_hit,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [FIELD_BITS-1:0]         csr_wdata
);

`include "assert_macros.svh"

   localparam int SIZE_BITS = COORD_BITS - 1;
   localparam int SUM_BITS  = (COORD_BITS + 3 > FIELD_BITS + 2) ? COORD_BITS + 3
                                                                 : FIELD_BITS + 2;
   localparam int MAG_BITS  = COORD_BITS + 1;
   localparam int RAD_BITS  = COORD_BITS;
   localparam int DIST_BITS = 2 * MAG_BITS + 1;

   typedef logic signed [SUM_BITS-1:0] sum_type;

   function automatic logic le_f(sum_type a, sum_type b, logic s);
      return s ? (a < b) : (a <= b);
   endfunction

   function automatic logic [MAG_BITS-1:0] mag_f(sum_type v);
      sum_type t;
      t = v[SUM_BITS-1] ? -v : v;
      return t[MAG_BITS-1:0];
   endfunction

   function automatic sum_type coord_f(logic [COORD_BITS-1:0] v);
      return sum_type'({{(SUM_BITS-COORD_BITS){v[COORD_BITS-1]}}, v});
   endfunction

   function automatic sum_type size_f(logic [SIZE_BITS-1:0] v);
      return sum_type'({{(SUM_BITS-SIZE_BITS){1'b0}}, v});
   endfunction

   logic pipe_en;

   // Field registers.
   logic [FIELD_BITS-1:0] field_w_ff, field_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_w_ff <= FIELD_WIDTH_RESET;
         field_h_ff <= FIELD_HEIGHT_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_FIELD_WIDTH) begin
            field_w_ff <= csr_wdata;
         end
         if (csr_index == CSR_FIELD_HEIGHT) begin
            field_h_ff <= csr_wdata;
         end
      end
   end

   assign csr_ready = 1'b1;

   // Decode stage: widened operands and the sums built from them.
   sum_type ax, ay, aw, ah, bx, by, bw, bh, fw, fh, zero;
   sum_type axw, ayh, axmw, axpw, aymw, aypw, bxw, byh, byw, bxmw, bymw;
   sum_type rad_wide;
   logic    s;
   logic    lx, gx, ly, gy;
   spct_ctl_type ctl_in;

   always_comb begin
      ax   = coord_f(req_a_x);
      ay   = coord_f(req_a_y);
      bx   = coord_f(req_b_x);
      by   = coord_f(req_b_y);
      aw   = size_f(req_a_w);
      ah   = size_f(req_a_h);
      bw   = size_f(req_b_w);
      bh   = size_f(req_b_h);
      fw   = sum_type'({{(SUM_BITS-FIELD_BITS){1'b0}}, field_w_ff});
      fh   = sum_type'({{(SUM_BITS-FIELD_BITS){1'b0}}, field_h_ff});
      zero = '0;
      s    = req_strict;

      axw  = ax + aw;
      ayh  = ay + ah;
      axmw = ax - aw;
      axpw = ax + aw;
      aymw = ay - aw;
      aypw = ay + aw;
      bxw  = bx + bw;
      byh  = by + bh;
      byw  = by + bw;
      bxmw = bx - bw;
      bymw = by - bw;

      // Where the circle centre sits against the rect edges.
      lx = bx < ax;
      gx = bx > axw;
      ly = by < ay;
      gy = by > ayh;

      ctl_in            = '0;
      ctl_in.op         = req_opcode;
      ctl_in.strict     = s;
      ctl_in.use_corner = (lx | gx) & (ly | gy);
      ctl_in.corner_x   = gx;
      ctl_in.corner_y   = gy;
      ctl_in.box_hit    = le_f(ax, bxw, s) & le_f(bxmw, axw, s) &
                          le_f(ay, byw, s) & le_f(bymw, ayh, s);
      ctl_in.bw_ge_aw   = bw >= aw;

      // Tests that need no squared distance.
      case (req_opcode)
         OP_RR_OVERLAP: begin
            ctl_in.lin_hit = le_f(bx, axw, s) & le_f(ax, bxw, s) &
                             le_f(by, ayh, s) & le_f(ay, byh, s);
         end
         OP_RR_INSIDE: begin
            ctl_in.lin_hit = (ax >= bx) & (axw <= bxw) & (ay >= by) & (ayh <= byh);
         end
         OP_CR_INSIDE: begin
            ctl_in.lin_hit = (axmw >= bx) & (axpw <= bxw) &
                             (aymw >= by) & (aypw <= byh);
         end
         OP_RECT_OUT_ANY: begin
            ctl_in.lin_hit = le_f(fw, axw, s) | le_f(ax, zero, s) |
                             le_f(fh, ayh, s) | le_f(ay, zero, s);
         end
         OP_RECT_OUT_ALL: begin
            ctl_in.lin_hit = le_f(fw, ax, s) | le_f(axw, zero, s) |
                             le_f(fh, ay, s) | le_f(ayh, zero, s);
         end
         OP_CIRC_OUT_ANY: begin
            ctl_in.lin_hit = le_f(fw, axpw, s) | le_f(axmw, zero, s) |
                             le_f(fh, aypw, s) | le_f(aymw, zero, s);
         end
         OP_CIRC_OUT_ALL: begin
            ctl_in.lin_hit = le_f(fw, axmw, s) | le_f(axpw, zero, s) |
                             le_f(fh, aymw, s) | le_f(aypw, zero, s);
         end
         default: begin
            ctl_in.lin_hit = 1'b0;
         end
      endcase

      // Radius whose square the distance is held against.
      if (req_opcode == OP_CC_OVERLAP) begin
         rad_wide = aw + bw;
      end else if (req_opcode == OP_CC_INSIDE) begin
         rad_wide = ctl_in.bw_ge_aw ? (bw - aw) : zero;
      end else begin
         rad_wide = bw;
      end
   end

   // Decode stage registers.
   logic                s1_valid_ff;
   spct_ctl_type        s1_ctl_ff;
   logic [MAG_BITS-1:0] s1_dx0_ff, s1_dx1_ff, s1_dy0_ff, s1_dy1_ff;
   logic [RAD_BITS-1:0] s1_rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_ctl_ff <= ctl_in;
         s1_dx0_ff <= mag_f(ax - bx);
         s1_dx1_ff <= mag_f(axw - bx);
         s1_dy0_ff <= mag_f(ay - by);
         s1_dy1_ff <= mag_f(ayh - by);
         s1_rad_ff <= rad_wide[RAD_BITS-1:0];
      end
   end

   // Squares and sums.
   logic                   d_valid;
   spct_ctl_type           d_ctl;
   logic [DIST_BITS-1:0]   d00, d01, d10, d11;
   logic [2*RAD_BITS-1:0]  rr;

   spct_dist #(
      .MAG_BITS (MAG_BITS),
      .RAD_BITS (RAD_BITS)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (s1_valid_ff),
      .in_ctl    (s1_ctl_ff),
      .dx0       (s1_dx0_ff),
      .dx1       (s1_dx1_ff),
      .dy0       (s1_dy0_ff),
      .dy1       (s1_dy1_ff),
      .rad       (s1_rad_ff),
      .out_valid (d_valid),
      .out_ctl   (d_ctl),
      .d00       (d00),
      .d01       (d01),
      .d10       (d10),
      .d11       (d11),
      .rr        (rr)
   );

   // Final compare and result select.
   logic [DIST_BITS-1:0] rr_wide, d_corner;
   logic                 hit_in;

   always_comb begin
      rr_wide = {{(DIST_BITS-2*RAD_BITS){1'b0}}, rr};

      case ({d_ctl.corner_x, d_ctl.corner_y})
         2'b00:   d_corner = d00;
         2'b01:   d_corner = d01;
         2'b10:   d_corner = d10;
         default: d_corner = d11;
      endcase

      case (d_ctl.op)
         OP_RC_OVERLAP: begin
            if (d_ctl.use_corner) begin
               hit_in = d_ctl.strict ? (d_corner < rr_wide) : (d_corner <= rr_wide);
            end else begin
               hit_in = d_ctl.box_hit;
            end
         end
         OP_CC_OVERLAP: begin
            hit_in = d_ctl.strict ? (d00 < rr_wide) : (d00 <= rr_wide);
         end
         OP_RC_INSIDE: begin
            hit_in = (d00 <= rr_wide) & (d01 <= rr_wide) &
                     (d10 <= rr_wide) & (d11 <= rr_wide);
         end
         OP_CC_INSIDE: begin
            hit_in = d_ctl.bw_ge_aw & (d00 <= rr_wide);
         end
         default: begin
            hit_in = d_ctl.lin_hit;
         end
      endcase
   end

   // Output register.
   logic rsp_valid_ff, rsp_hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_hit_ff <= hit_in;
      end
   end

   // The whole pipeline moves unless a finished word waits at the output.
   assign pipe_en   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !pipe_en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;

   // Unused opcodes never report a hit from the decode stage.
   `SPCT_ASSERT_ALWAYS(a_unused_op_no_hit, clock, reset, !(s1_valid_ff && (s1_ctl_ff.op > OP_CIRC_OUT_ALL)) || !s1_ctl_ff.lin_hit)
   // A larger inner circle leaves a zero radius for the containment square.
   `SPCT_ASSERT_ALWAYS(a_cc_inside_rad, clock, reset, !(s1_valid_ff && (s1_ctl_ff.op == OP_CC_INSIDE) && !s1_ctl_ff.bw_ge_aw) || (s1_rad_ff == '0))
   // A held pipeline keeps its decode stage and output in place.
   `SPCT_ASSERT_NEXT(a_stall_holds, clock, reset, !pipe_en, $stable(s1_valid_ff) && $stable(s1_ctl_ff) && $stable(rsp_valid_ff) && $stable(rsp_hit_ff))

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the shape pair collision test.
// Depends on spct_pkg and shape_pair_collision_test; it predicts every hit bit on its own.
`timescale 1ns / 1ps

module testbench;
   import spct_pkg::*;

   localparam int CB = COORD_BITS_DEFAULT;
   localparam int CYCLE_LIMIT = 600000;
   localparam int ITEMS_PER_PHASE = 305;

   // One shape pair as it goes onto the request channel.
   typedef struct {
      logic [OPCODE_BITS-1:0] opcode;
      logic                   strict;
      logic signed [CB-1:0]   a_x;
      logic signed [CB-1:0]   a_y;
      logic [CB-2:0]          a_w;
      logic [CB-2:0]          a_h;
      logic signed [CB-1:0]   b_x;
      logic signed [CB-1:0]   b_y;
      logic [CB-2:0]          b_w;
      logic [CB-2:0]          b_h;
   } shape_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   wire logic              req_stall;
   logic [OPCODE_BITS-1:0] req_opcode = '0;
   logic                   req_strict = 1'b0;
   logic signed [CB-1:0]   req_a_x = '0;
   logic signed [CB-1:0]   req_a_y = '0;
   logic [CB-2:0]          req_a_w = '0;
   logic [CB-2:0]          req_a_h = '0;
   logic signed [CB-1:0]   req_b_x = '0;
   logic signed [CB-1:0]   req_b_y = '0;
   logic [CB-2:0]          req_b_w = '0;
   logic [CB-2:0]          req_b_h = '0;
   wire logic              rsp_valid;
   logic                   rsp_stall = 1'b0;
   wire logic              rsp_hit;
   logic                   csr_valid = 1'b0;
   wire logic              csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [FIELD_BITS-1:0]  csr_wdata = '0;

   // Testbench copy of the field registers.
   logic [FIELD_BITS-1:0] field_w_cfg = FIELD_WIDTH_RESET;
   logic [FIELD_BITS-1:0] field_h_cfg = FIELD_HEIGHT_RESET;

   shape_pair_type pending_pairs[$];
   bit             hit_expected[$];
   shape_pair_type drive_pair;
   int          words_presented = 0;
   int          words_accepted = 0;
   int          mismatch_count = 0;
   int          cycle_count = 0;

   // Sender burst state and receiver stall state.
   int          burst_left = 1;
   int          idle_left = 0;
   int          stall_mode = 0;
   int          stall_left = 0;
   logic [7:0]  stall_pattern = 8'h00;

   shape_pair_collision_test DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_strict(req_strict),
      .req_a_x(req_a_x),
      .req_a_y(req_a_y),
      .req_a_w(req_a_w),
      .req_a_h(req_a_h),
      .req_b_x(req_b_x),
      .req_b_y(req_b_y),
      .req_b_w(req_b_w),
      .req_b_h(req_b_h),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_hit(rsp_hit),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Edge-inclusive or strict comparison, chosen by the strict bit.
   function automatic bit at_most(input longint lhs, input longint rhs, input bit s);
      return s ? (lhs < rhs) : (lhs <= rhs);
   endfunction

   function automatic longint square(input longint d);
      return d * d;
   endfunction

   function automatic longint dist_sq(input longint px, input longint py,
                                      input longint cx, input longint cy);
      return square(px - cx) + square(py - cy);
   endfunction

   // Expected hit bit for one pair, with all sums widened to 64 bits.
   function automatic bit collision_hit(input shape_pair_type p);
      longint ax, ay, aw, ah, bx, by, bw, bh, fw, fh, rx, ty, px, py, rr;
      bit     s, hit, corner;
      ax = p.a_x; ay = p.a_y; aw = p.a_w; ah = p.a_h;
      bx = p.b_x; by = p.b_y; bw = p.b_w; bh = p.b_h;
      fw = field_w_cfg; fh = field_h_cfg;
      s = p.strict;
      hit = 1'b0;
      case (p.opcode)
         OP_RR_OVERLAP: begin
            hit = at_most(bx, ax + aw, s) && at_most(ax, bx + bw, s) &&
                  at_most(by, ay + ah, s) && at_most(ay, by + bh, s);
         end
         OP_RC_OVERLAP: begin
            // A centre off a corner is measured against that corner point.
            rx = ax + aw; ty = ay + ah;
            corner = 1'b1; px = ax; py = ay;
            if (bx < ax && by < ay) begin
               px = ax; py = ay;
            end else if (bx > rx && by < ay) begin
               px = rx; py = ay;
            end else if (bx < ax && by > ty) begin
               px = ax; py = ty;
            end else if (bx > rx && by > ty) begin
               px = rx; py = ty;
            end else begin
               corner = 1'b0;
            end
            if (corner)
               hit = at_most(dist_sq(px, py, bx, by), square(bw), s);
            else
               hit = at_most(ax, bx + bw, s) && at_most(bx - bw, rx, s) &&
                     at_most(ay, by + bw, s) && at_most(by - bw, ty, s);
         end
         OP_CC_OVERLAP: begin
            hit = at_most(dist_sq(ax, ay, bx, by), square(aw + bw), s);
         end
         OP_RR_INSIDE: begin
            hit = ax >= bx && ax + aw <= bx + bw && ay >= by && ay + ah <= by + bh;
         end
         OP_RC_INSIDE: begin
            rr = square(bw);
            hit = dist_sq(ax, ay, bx, by) <= rr && dist_sq(ax, ay + ah, bx, by) <= rr &&
                  dist_sq(ax + aw, ay, bx, by) <= rr &&
                  dist_sq(ax + aw, ay + ah, bx, by) <= rr;
         end
         OP_CR_INSIDE: begin
            hit = ax - aw >= bx && ax + aw <= bx + bw && ay - aw >= by && ay + aw <= by + bh;
         end
         OP_CC_INSIDE: begin
            hit = (bw >= aw) && dist_sq(ax, ay, bx, by) <= square(bw - aw);
         end
         OP_RECT_OUT_ANY: begin
            hit = at_most(fw, ax + aw, s) || at_most(ax, 0, s) ||
                  at_most(fh, ay + ah, s) || at_most(ay, 0, s);
         end
         OP_RECT_OUT_ALL: begin
            hit = at_most(fw, ax, s) || at_most(ax + aw, 0, s) ||
                  at_most(fh, ay, s) || at_most(ay + ah, 0, s);
         end
         OP_CIRC_OUT_ANY: begin
            hit = at_most(fw, ax + aw, s) || at_most(ax - aw, 0, s) ||
                  at_most(fh, ay + aw, s) || at_most(ay - aw, 0, s);
         end
         OP_CIRC_OUT_ALL: begin
            hit = at_most(fw, ax - aw, s) || at_most(ax + aw, 0, s) ||
                  at_most(fh, ay - aw, s) || at_most(ay + aw, 0, s);
         end
         default: begin
            hit = 1'b0;
         end
      endcase
      return hit;
   endfunction

   task automatic report_mismatch(input string why);
      mismatch_count++;
      $display("mismatch at cycle %0d: %s", cycle_count, why);
   endtask

   task automatic add_pair(input logic [OPCODE_BITS-1:0] op, input bit s,
                           input int ax, input int ay, input int aw, input int ah,
                           input int bx, input int by, input int bw, input int bh);
      shape_pair_type p;
      p.opcode = op; p.strict = s;
      p.a_x = CB'(ax); p.a_y = CB'(ay); p.a_w = (CB-1)'(aw); p.a_h = (CB-1)'(ah);
      p.b_x = CB'(bx); p.b_y = CB'(by); p.b_w = (CB-1)'(bw); p.b_h = (CB-1)'(bh);
      pending_pairs.push_back(p);
   endtask

   // Random pair: mostly shapes placed near each other or near the field
   // area, with some words of pure noise and some unused opcodes.
   function automatic shape_pair_type make_random_pair();
      shape_pair_type p;
      int          span, off_x, off_y;
      bit          bounds_op;
      if ($urandom_range(0, 15) == 0)
         p.opcode = OPCODE_BITS'($urandom_range(11, 15));
      else
         p.opcode = OPCODE_BITS'($urandom_range(0, 10));
      p.strict = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 7) == 0) begin
         p.a_x = CB'($urandom); p.a_y = CB'($urandom);
         p.a_w = (CB-1)'($urandom); p.a_h = (CB-1)'($urandom);
         p.b_x = CB'($urandom); p.b_y = CB'($urandom);
         p.b_w = (CB-1)'($urandom); p.b_h = (CB-1)'($urandom);
      end else begin
         case ($urandom_range(0, 3))
            0: span = 8;
            1: span = 100;
            2: span = 3000;
            default: span = 32767;
         endcase
         p.a_w = (CB-1)'($urandom_range(0, span));
         p.a_h = (CB-1)'($urandom_range(0, span));
         p.b_w = (CB-1)'($urandom_range(0, span));
         p.b_h = (CB-1)'($urandom_range(0, span));
         // Containment needs a smaller first shape to hit at all.
         if (p.opcode >= OP_RR_INSIDE && p.opcode <= OP_CC_INSIDE && $urandom_range(0, 1)) begin
            p.a_w = p.a_w >> $urandom_range(1, 4);
            p.a_h = p.a_h >> $urandom_range(1, 4);
         end
         off_x = int'($urandom_range(0, 2 * span)) - span;
         off_y = int'($urandom_range(0, 2 * span)) - span;
         bounds_op = p.opcode >= OP_RECT_OUT_ANY && p.opcode <= OP_CIRC_OUT_ALL;
         p.b_x = CB'($urandom);
         p.b_y = CB'($urandom);
         if (bounds_op) begin
            p.a_x = CB'(longint'($urandom_range(0, field_w_cfg)) + off_x);
            p.a_y = CB'(longint'($urandom_range(0, field_h_cfg)) + off_y);
         end else begin
            p.a_x = CB'(longint'(p.b_x) + off_x);
            p.a_y = CB'(longint'(p.b_y) + off_y);
         end
         // Put an edge exactly on another now and then, so the strict bit matters.
         if ($urandom_range(0, 5) == 0) begin
            if (bounds_op)
               p.a_x = CB'(longint'(field_w_cfg) - longint'(p.a_w));
            else
               p.b_x = CB'(longint'(p.a_x) + longint'(p.a_w));
         end
      end
      return p;
   endfunction

   // Waits until every queued word has gone in and every result has come out.
   task automatic drain_pipeline();
      while (pending_pairs.size() != 0 || words_accepted != words_presented ||
             hit_expected.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_field_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                                  input logic [FIELD_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Driver: presents one word at a time, in bursts mostly separated by idle gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || words_accepted == words_presented) begin
         if (idle_left != 0) begin
            idle_left <= idle_left - 1;
            req_valid <= 1'b0;
         end else if (pending_pairs.size() != 0) begin
            drive_pair = pending_pairs.pop_front();
            req_opcode <= drive_pair.opcode;
            req_strict <= drive_pair.strict;
            req_a_x <= drive_pair.a_x;
            req_a_y <= drive_pair.a_y;
            req_a_w <= drive_pair.a_w;
            req_a_h <= drive_pair.a_h;
            req_b_x <= drive_pair.b_x;
            req_b_y <= drive_pair.b_y;
            req_b_w <= drive_pair.b_w;
            req_b_h <= drive_pair.b_h;
            req_valid <= 1'b1;
            words_presented = words_presented + 1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               idle_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stall mode changes every so often; the last mode rotates a pattern.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(16, 160);
         stall_pattern <= 8'($urandom);
         rsp_stall <= 1'b0;
      end else begin
         stall_left <= stall_left - 1;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: begin
               rsp_stall <= stall_pattern[0];
               stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
            end
         endcase
      end
   end

   // Monitor: checks results, predicts accepted words and tracks register writes.
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (reset) begin
         field_w_cfg = FIELD_WIDTH_RESET;
         field_h_cfg = FIELD_HEIGHT_RESET;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (hit_expected.size() == 0)
               report_mismatch("result with no word outstanding");
            else if (rsp_hit !== hit_expected[0])
               report_mismatch($sformatf("hit is %b, predicted %b", rsp_hit, hit_expected[0]));
            if (hit_expected.size() != 0)
               void'(hit_expected.pop_front());
         end
         if (req_valid && !req_stall) begin
            hit_expected.push_back(collision_hit(drive_pair));
            words_accepted = words_accepted + 1;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_FIELD_WIDTH)
               field_w_cfg = csr_wdata;
            else if (csr_index == CSR_FIELD_HEIGHT)
               field_h_cfg = csr_wdata;
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Stimulus: directed pairs at the reset field size, then random phases
   // under several field sizes written while the block is idle.
   initial begin
      logic [FIELD_BITS-1:0] widths[6];
      logic [FIELD_BITS-1:0] heights[6];
      widths  = '{15'd1, 15'd32767, 15'd1, 15'd32767, 15'd0, 15'd0};
      heights = '{15'd1, 15'd32767, 15'd32767, 15'd1, 15'd0, 15'd0};
      widths[4]  = FIELD_BITS'($urandom_range(1, 32767));
      heights[4] = FIELD_BITS'($urandom_range(1, 32767));
      widths[5]  = FIELD_BITS'($urandom_range(1, 2000));
      heights[5] = FIELD_BITS'($urandom_range(1, 2000));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Edges that touch, with and without the strict bit.
      add_pair(OP_RR_OVERLAP, 0, 0, 0, 10, 10, 10, 0, 5, 5);
      add_pair(OP_RR_OVERLAP, 1, 0, 0, 10, 10, 10, 0, 5, 5);
      add_pair(OP_RR_OVERLAP, 0, -32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767);
      // Circle centre off each corner of the rectangle, and off one side.
      add_pair(OP_RC_OVERLAP, 0, 0, 0, 10, 10, 13, 14, 5, 0);
      add_pair(OP_RC_OVERLAP, 1, 0, 0, 10, 10, 13, 14, 5, 0);
      add_pair(OP_RC_OVERLAP, 0, 0, 0, 10, 10, -3, -4, 5, 0);
      add_pair(OP_RC_OVERLAP, 0, 0, 0, 10, 10, -3, 14, 4, 0);
      add_pair(OP_RC_OVERLAP, 1, 0, 0, 10, 10, 13, -4, 5, 0);
      add_pair(OP_RC_OVERLAP, 0, 0, 0, 10, 10, 15, 5, 5, 0);
      add_pair(OP_CC_OVERLAP, 0, 0, 0, 3, 0, 6, 8, 7, 0);
      add_pair(OP_CC_OVERLAP, 1, 0, 0, 3, 0, 6, 8, 7, 0);
      add_pair(OP_CC_OVERLAP, 0, 32767, 32767, 32767, 0, -32768, -32768, 32767, 0);
      add_pair(OP_RR_INSIDE, 0, 2, 2, 3, 3, 0, 0, 10, 10);
      add_pair(OP_RC_INSIDE, 0, 1, 1, 2, 2, 0, 0, 5, 0);
      add_pair(OP_RC_INSIDE, 1, -32768, -32768, 32767, 32767, 0, 0, 32767, 32767);
      add_pair(OP_CR_INSIDE, 0, 5, 5, 5, 0, 0, 0, 10, 10);
      add_pair(OP_CC_INSIDE, 0, 1, 0, 3, 0, 0, 0, 5, 0);
      // Inner radius larger than the outer one never fits.
      add_pair(OP_CC_INSIDE, 0, 0, 0, 6, 0, 0, 0, 5, 0);
      add_pair(OP_RECT_OUT_ANY, 0, 630, 0, 10, 10, 0, 0, 0, 0);
      add_pair(OP_RECT_OUT_ANY, 1, 630, 0, 10, 10, 0, 0, 0, 0);
      add_pair(OP_RECT_OUT_ALL, 0, 640, 10, 5, 5, 0, 0, 0, 0);
      add_pair(OP_CIRC_OUT_ANY, 1, 5, 5, 5, 0, 0, 0, 0, 0);
      add_pair(OP_CIRC_OUT_ALL, 0, -10, 100, 10, 0, 0, 0, 0, 0);
      // Unused opcodes and zero sizes.
      add_pair(4'd11, 1, -1, -1, 32767, 32767, -1, -1, 32767, 32767);
      add_pair(4'd15, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_pair(OP_RR_OVERLAP, 1, 5, 5, 0, 0, 5, 5, 0, 0);
      drain_pipeline();

      for (int phase = 0; phase < 6; phase++) begin
         write_field_reg(CSR_FIELD_WIDTH, widths[phase]);
         write_field_reg(CSR_FIELD_HEIGHT, heights[phase]);
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            pending_pairs.push_back(make_random_pair());
         drain_pipeline();
      end

      if (hit_expected.size() != 0)
         report_mismatch("words left without a result");
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
